[rtl/modulo_bin_histogram_assert.svh]
// Assertion macros shared by the histogram RTL files.
// Each file that asserts includes this header; the macros expect i_clk and i_rst_n in scope.
`ifndef MODULO_BIN_HISTOGRAM_ASSERT_SVH
`define MODULO_BIN_HISTOGRAM_ASSERT_SVH

// Checks a property on every clock edge outside of reset.
`define MBH_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by a consequence in the next.
`define MBH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mbh_pkg.sv]
// Shared constants, types and command encoding of the modulo bin histogram.
// Used by every module of the block; depends on nothing else.
package mbh_pkg;

    localparam int BIN_COUNT   = 100;
    localparam int COUNT_WIDTH = 32;

    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int VALUE_W     = 16;
    localparam int INDEX_W     = 7;
    localparam int NUMBER_W    = 7;
    localparam int OUT_COUNT_W = 32;
    localparam int FUNC_W      = 2;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Modulo by a constant through a reciprocal multiply. With the shift set to the value
    // width plus the bin index width, the rounded-up reciprocal gives the exact quotient
    // for every 16-bit value.
    localparam int    MOD_SHIFT = VALUE_W + $clog2(BIN_COUNT);
    localparam int    RECIP_W   = VALUE_W + 2;
    localparam longint MOD_RECIP =
        ((longint'(1) << MOD_SHIFT) + longint'(BIN_COUNT) - 1) / longint'(BIN_COUNT);
    localparam int    PROD_W    = VALUE_W + RECIP_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD   = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2
    } t_func;

    // What the back end does with a queued command.
    typedef enum logic [1:0] {
        KD_ADD,
        KD_READ,
        KD_CLEAR,
        KD_ZERO
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BIN_W-1:0]    addr;
        logic [NUMBER_W-1:0] number;
    } t_cmd;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } t_bstate;

endpackage

[rtl/mbh_front.sv]
// Front end of the histogram: takes input items and classifies them into back-end commands.
// Depends on mbh_pkg; feeds mbh_queue.
module mbh_front
    import mbh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [VALUE_W-1:0]  i_sample_value,
    input  logic [INDEX_W-1:0]  i_bin_index,
    input  logic                i_q_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic                r_vld;
    logic [FUNC_W-1:0]   r_func;
    logic [VALUE_W-1:0]  r_value;
    logic [INDEX_W-1:0]  r_index;
    logic [PROD_W-1:0]   r_prod;

    logic [VALUE_W-1:0]  quot;
    logic [VALUE_W-1:0]  rem;
    logic                in_range;

    assign o_tready = !r_vld || !i_q_full;
    assign o_push   = r_vld && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_tready) begin
            r_vld <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_func  <= i_func;
            r_value <= i_sample_value;
            r_index <= i_bin_index;
            r_prod  <= PROD_W'(i_sample_value) * PROD_W'(MOD_RECIP);
        end
    end

    always_comb begin
        quot     = VALUE_W'(r_prod >> MOD_SHIFT);
        rem      = r_value - VALUE_W'(quot * VALUE_W'(BIN_COUNT));
        in_range = 32'(r_index) < BIN_COUNT;
        o_cmd    = '{kind: KD_ZERO, addr: '0, number: '0};
        case (r_func)
            FN_ADD: begin
                o_cmd.kind   = KD_ADD;
                o_cmd.addr   = BIN_W'(rem);
                o_cmd.number = NUMBER_W'(BIN_W'(rem));
            end
            FN_READ: begin
                // An out-of-range read echoes the index with a zero count.
                o_cmd.kind   = in_range ? KD_READ : KD_ZERO;
                o_cmd.addr   = BIN_W'(r_index);
                o_cmd.number = NUMBER_W'(r_index);
            end
            FN_CLEAR: begin
                o_cmd.kind = KD_CLEAR;
            end
            default: begin
                o_cmd.kind = KD_ZERO;
            end
        endcase
    end

endmodule

[rtl/mbh_queue.sv]
// Short command queue between the histogram front end and back end.
// Depends on mbh_pkg for the command type and depth.
`include "modulo_bin_histogram_assert.svh"

module mbh_queue
    import mbh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    `MBH_ASSERT(a_push_not_full, !(i_push && o_full), "push into a full command queue")
    `MBH_ASSERT(a_pop_not_empty, !(i_pop && o_empty), "pop from an empty command queue")

endmodule

[rtl/mbh_back.sv]
// Back end of the histogram: bin counter memory, read-modify-write and the result register.
// Depends on mbh_pkg; takes commands from mbh_queue.
`include "modulo_bin_histogram_assert.svh"

module mbh_back
    import mbh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_cmd                   i_head,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [NUMBER_W-1:0]    o_bin_number,
    output logic [OUT_COUNT_W-1:0] o_bin_count
);

    t_bstate                r_state;
    t_bstate                n_state;
    t_cmd                   r_cmd;
    logic [COUNT_WIDTH-1:0] r_mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic [BIN_COUNT-1:0]   r_valid;
    logic                   r_byp;
    logic [COUNT_WIDTH-1:0] r_byp_data;
    logic                   r_out_vld;
    logic [NUMBER_W-1:0]    r_out_number;
    logic [OUT_COUNT_W-1:0] r_out_count;

    logic                   out_free;
    logic                   done;
    logic                   head_reads;
    logic [COUNT_WIDTH-1:0] old_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [OUT_COUNT_W-1:0] res_count;

    assign o_tvalid     = r_out_vld;
    assign o_bin_number = r_out_number;
    assign o_bin_count  = r_out_count;

    always_comb begin
        out_free   = !r_out_vld || i_tready;
        done       = (r_state == BS_EXEC) && out_free;
        o_pop      = !i_q_empty && ((r_state == BS_IDLE) || done);
        head_reads = (i_head.kind == KD_ADD) || (i_head.kind == KD_READ);
        // The memory read of a command issued while the previous add writes the same bin
        // returns the old count, so the freshly written count is forwarded instead.
        if (r_byp) begin
            old_count = r_byp_data;
        end else if (r_valid[r_cmd.addr]) begin
            old_count = r_rd_data;
        end else begin
            old_count = '0;
        end
        if ((r_cmd.kind == KD_ADD) && (old_count != '1)) begin
            new_count = old_count + 1'b1;
        end else begin
            new_count = old_count;
        end
        case (r_cmd.kind)
            KD_ADD:  res_count = OUT_COUNT_W'(new_count);
            KD_READ: res_count = OUT_COUNT_W'(new_count);
            default: res_count = '0;
        endcase
    end

    always_comb begin
        case (r_state)
            BS_IDLE: n_state = o_pop ? BS_EXEC : BS_IDLE;
            BS_EXEC: begin
                if (done) begin
                    n_state = o_pop ? BS_EXEC : BS_IDLE;
                end else begin
                    n_state = BS_EXEC;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_valid   <= '0;
            r_byp     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done && (r_cmd.kind == KD_CLEAR)) begin
                r_valid <= '0;
            end else if (done && (r_cmd.kind == KD_ADD)) begin
                r_valid[r_cmd.addr] <= 1'b1;
            end
            if (o_pop) begin
                r_byp <= done && (r_cmd.kind == KD_ADD) && head_reads
                         && (i_head.addr == r_cmd.addr);
            end else if (done) begin
                // The back end goes idle, so no command is left to forward to.
                r_byp <= 1'b0;
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd      <= i_head;
            r_byp_data <= new_count;
        end
        if (done) begin
            r_out_number <= r_cmd.number;
            r_out_count  <= res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && head_reads) begin
            r_rd_data <= r_mem[i_head.addr];
        end
        if (done && (r_cmd.kind == KD_ADD)) begin
            r_mem[r_cmd.addr] <= new_count;
        end
    end

    `MBH_ASSERT(a_byp_in_exec, !r_byp || (r_state == BS_EXEC), "forwarding set outside execution")
    `MBH_ASSERT_NEXT(a_clear_empties, done && (r_cmd.kind == KD_CLEAR), r_valid == '0, "clear left a valid bin")

endmodule

[rtl/modulo_bin_histogram.sv]
// Top level of the modulo bin histogram: stream ports around front end, queue and back end.
// Depends on mbh_pkg, mbh_front, mbh_queue and mbh_back.
//
//  Channel   Direction  Carries
//  s_axis    in         one operation: add sample, read bin or clear all bins
//  m_axis    out        one result per operation: bin number and its count
//
// An item waits in the front register, where its bin (sample modulo the bin count) is found
// by a reciprocal multiply, then waits in a four-entry command queue. The back end reads
// the bin counter from its registered memory and retires the command once the result
// register is free, overlapping with the read of the following command, so a steady stream
// moves one item per cycle while m_axis does not stall. Reset is synchronous and marks every
// bin zero through per-bin valid bits, so the block takes items as soon as reset is released;
// a clear item marks every bin zero at once. A stall on m_axis holds the result register,
// then the back end, then fills the queue before s_axis_tready drops.
module modulo_bin_histogram
    import mbh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // sample_value [15:0], bin_index [22:16]
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // func [1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // bin_number [6:0], bin_count [38:7]
);

    logic                   q_full;
    logic                   q_empty;
    logic                   push;
    logic                   pop;
    t_cmd                   push_cmd;
    t_cmd                   head_cmd;
    logic [NUMBER_W-1:0]    bin_number;
    logic [OUT_COUNT_W-1:0] bin_count;

    // Classifies each operation and computes the bin of a sample.
    mbh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tvalid       (s_axis_tvalid),
        .o_tready       (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_sample_value (s_axis_tdata[VALUE_W-1:0]),
        .i_bin_index    (s_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W]),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Decouples the front end from stalls of the counter update and result path.
    mbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // Performs the counter update or read and holds the result.
    mbh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_bin_number (bin_number),
        .o_bin_count  (bin_count)
    );

    // The last bit pads the result to whole bytes.
    assign m_axis_tdata = {1'b0, bin_count, bin_number};

endmodule

[tb/histogram_checker.sv]
// Checker for the modulo bin histogram: watches both stream channels, keeps its own bin table,
// and compares every result item with the prediction. Depends on mbh_pkg only.
module histogram_checker
    import mbh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // sample_value [15:0], bin_index [22:16]
    input  logic [FUNC_W-1:0]    i_s_tuser,   // func [1:0]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // bin_number [6:0], bin_count [38:7]
    output int                   o_pending,
    output int                   o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [NUMBER_W-1:0]    number;
        logic [OUT_COUNT_W-1:0] count;
    } t_bin_result;

    logic [COUNT_WIDTH-1:0] bin_tally [BIN_COUNT];
    t_bin_result            expected_bins [$];

    // Applies one operation to the local bin table and returns the result it should produce.
    function automatic t_bin_result tally_op(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] val,
                                             logic [INDEX_W-1:0] idx);
        t_bin_result r;
        int unsigned bin;
        r = '0;
        case (fn)
            FN_ADD: begin
                bin = val % BIN_COUNT;
                if (bin_tally[bin] != COUNT_MAX) begin
                    bin_tally[bin] = bin_tally[bin] + 1'b1;
                end
                r.number = NUMBER_W'(bin);
                r.count  = OUT_COUNT_W'(bin_tally[bin]);
            end
            FN_READ: begin
                r.number = NUMBER_W'(idx);
                if (idx < BIN_COUNT) begin
                    r.count = OUT_COUNT_W'(bin_tally[idx]);
                end
            end
            FN_CLEAR: begin
                foreach (bin_tally[i]) bin_tally[i] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bin_result seen;
        t_bin_result want;
        if (!i_rst_n) begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            expected_bins.delete();
            o_mismatches = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_bins.push_back(tally_op(i_s_tuser, i_s_tdata[VALUE_W-1:0],
                                                 i_s_tdata[VALUE_W +: INDEX_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.number = i_m_tdata[NUMBER_W-1:0];
                seen.count  = i_m_tdata[NUMBER_W +: OUT_COUNT_W];
                if (expected_bins.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result item with nothing expected: bin %0d count %0d",
                                 $realtime, seen.number, seen.count);
                    end
                end else begin
                    want = expected_bins.pop_front();
                    if (seen.number !== want.number || seen.count !== want.count) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch: bin_number exp %0d got %0d, bin_count exp %0d got %0d",
                                     $realtime, want.number, seen.number, want.count,
                                     seen.count);
                        end
                    end
                end
            end
        end
        o_pending = expected_bins.size();
    end

endmodule

[tb/tb_modulo_bin_histogram.sv]
// Testbench top for the modulo bin histogram: clock, reset, item stimulus and result stalls.
// Depends on mbh_pkg, the modulo_bin_histogram RTL and the histogram_checker module.
module tb_modulo_bin_histogram;
    import mbh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The selector value that the block must ignore; it is not part of the package encoding.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 8;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 325;
    localparam int DENSE_ITEMS   = 40;     // back-to-back items offered during the long hold
    localparam int HOLD_CYCLES   = 400;    // length of the long receiver hold-off
    localparam int IDLE_LIMIT    = 4000;   // cycles with no accepted item before giving up
    localparam int TAIL_CYCLES   = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;      // sample_value [15:0], bin_index [22:16]
    logic [FUNC_W-1:0]    s_axis_tuser = FN_ADD;  // func [1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;           // bin_number [6:0], bin_count [38:7]

    int pending;
    int mismatches;

    // Sender state: burst bookkeeping, the largest gap between bursts, and a few bins that
    // take a large share of the traffic so that counts grow and back-to-back hits on one bin occur.
    int burst_left = 0;
    int gap_max    = 2;
    int hot_bins [4];

    // Receiver hold-off requests: the stimulus bumps hold_reqs, the receiver notices the change.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int phase_left = 0;
    int stall_pct = 0;

    int idle_cycles = 0;
    int n_add = 0, n_read = 0, n_read_oob = 0, n_clear = 0, n_unused = 0;

    always #5 i_clk = ~i_clk;

    modulo_bin_histogram DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    histogram_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Offers one item and returns at the clock edge where it is accepted. A new burst starts
    // with a random gap unless no_gap is set. Every call is made right after a rising edge.
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] idx, input bit no_gap = 1'b0);
        int gap;
        if (burst_left == 0) begin
            gap = no_gap ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, idx, val};
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (fn)
            FN_ADD:   n_add++;
            FN_READ:  begin
                n_read++;
                if (idx >= BIN_COUNT) n_read_oob++;
            end
            FN_CLEAR: n_clear++;
            default:  n_unused++;
        endcase
    endtask

    // Stops offering items and waits until every expected result has been taken. The count
    // is read on the falling edge so that the checker has settled for that cycle.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        burst_left = 0;
    endtask

    // One random operation. Adds dominate; half of them land on a hot bin through a random
    // multiple of the bin count, the rest use a fully random sample. Reads mostly target the
    // hot bins or any valid bin, with a share past the end of the table. Clears are rare so
    // that counts can build up, and unused selectors carry random fields.
    task automatic random_op(input bit no_gap);
        int pick;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        val  = VALUE_W'($urandom);
        idx  = INDEX_W'($urandom);
        if (pick < 58) begin
            if ($urandom_range(0, 1) == 1) begin
                val = VALUE_W'(hot_bins[$urandom_range(0, 3)] + BIN_COUNT * $urandom_range(0, 654));
            end
            send_op(FN_ADD, val, idx, no_gap);
        end else if (pick < 92) begin
            case ($urandom_range(0, 3))
                0:       idx = INDEX_W'($urandom_range(BIN_COUNT, 127));
                1:       idx = INDEX_W'($urandom_range(0, BIN_COUNT - 1));
                default: idx = INDEX_W'(hot_bins[$urandom_range(0, 3)]);
            endcase
            send_op(FN_READ, val, idx, no_gap);
        end else if (pick < 94) begin
            send_op(FN_CLEAR, val, idx, no_gap);
        end else begin
            send_op(FN_UNUSED, val, idx, no_gap);
        end
    endtask

    // Receiver: a long hold when the stimulus asks for one, otherwise a stall rate that is
    // redrawn for each phase of random length, from never stalling to stalling most of the time.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves an item means a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Right after reset every bin reads zero, including the first and the
        // last bin; indexes past the table echo the index with a zero count.
        send_op(FN_READ, 16'h0000, 7'd0);
        send_op(FN_READ, 16'hFFFF, 7'd99);
        send_op(FN_READ, 16'h0000, 7'd100);
        send_op(FN_READ, 16'hFFFF, 7'd127);
        // Smallest and largest samples, the last bin, and a wrap back onto bin 0.
        send_op(FN_ADD, 16'h0000, 7'd127);
        send_op(FN_ADD, 16'hFFFF, 7'd0);
        send_op(FN_ADD, 16'd99, 7'd0);
        send_op(FN_ADD, 16'd100, 7'd0);
        // Back-to-back adds to one bin exercise the read-modify-write forwarding.
        send_op(FN_ADD, 16'd135, 7'd0, 1'b1);
        send_op(FN_ADD, 16'd235, 7'd0, 1'b1);
        send_op(FN_ADD, 16'd35, 7'd0, 1'b1);
        send_op(FN_READ, 16'd0, 7'd35, 1'b1);
        send_op(FN_READ, 16'd0, 7'd0);
        // The unused selector changes nothing and returns zeros whatever the fields hold.
        send_op(FN_UNUSED, 16'hFFFF, 7'd127);
        send_op(FN_READ, 16'd0, 7'd35);
        // A clear zeroes every bin at once; an add right behind it starts again from one.
        send_op(FN_CLEAR, 16'hFFFF, 7'd127);
        send_op(FN_ADD, 16'd35, 7'd0, 1'b1);
        send_op(FN_READ, 16'd0, 7'd35, 1'b1);
        send_op(FN_READ, 16'd0, 7'd0);
        send_op(FN_READ, 16'd0, 7'd99);
        send_op(FN_CLEAR, 16'h0000, 7'd0);
        send_op(FN_READ, 16'd0, 7'd35);
        drain();

        // Random part in segments. Each segment picks new hot bins and a sender gap limit;
        // the third starts with a long receiver hold while items keep coming back to back,
        // so the queue fills and the input stalls. Every segment ends with a full drain.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0, 2:    gap_max = 0;
                1:       gap_max = 3;
                3:       gap_max = 8;
                4:       gap_max = 1;
                default: gap_max = 15;
            endcase
            foreach (hot_bins[i]) hot_bins[i] = $urandom_range(0, BIN_COUNT - 1);
            if (seg == 1) begin
                hot_bins[0] = 0;
                hot_bins[1] = BIN_COUNT - 1;
            end
            if (seg == 2) hold_reqs++;
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
                random_op(seg == 2 && k < DENSE_ITEMS);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d adds, %0d reads (%0d past the last bin), %0d clears, %0d unused",
                 n_add, n_read, n_read_oob, n_clear, n_unused);
        $display("summary: %0d mismatched results, %0d results never delivered",
                 mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[modulo_bin_histogram.f]
+incdir+rtl
rtl/mbh_pkg.sv
rtl/mbh_front.sv
rtl/mbh_queue.sv
rtl/mbh_back.sv
rtl/modulo_bin_histogram.sv
tb/histogram_checker.sv
tb/tb_modulo_bin_histogram.sv
